@@ rtl/core/bbc_pkg.sv @@
// Shared types and constants of the block buffer cache tag and policy engine.
package bbc_pkg;

  // Default slot count of the cache
  localparam int NumSlotsDefault = 16;

  // Pin counter width and its saturation value
  localparam int PinW = 16;
  localparam logic [PinW-1:0] PinMax = '1;

  // Request kinds
  typedef enum logic [1:0] {
    KindGet     = 2'd0,
    KindNew     = 2'd1,
    KindDirty   = 2'd2,
    KindRelease = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatNoBlock   = 2'd1,
    StatBusy      = 2'd2,
    StatNotPinned = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPinWr,
    StSweep,
    StTake,
    StRel,
    StDone
  } state_e;

  // Tag of one slot: owner key and block number
  typedef struct packed {
    logic [31:0] owner;
    logic [63:0] block;
  } tag_t;

  // Request item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] owner_key;
    logic [63:0] block_no;
    logic [3:0]  slot_sel;
  } req_t;

  // Result item
  typedef struct packed {
    logic [3:0]  slot;
    status_e     status;
    logic        hit;
    logic        fetch_req;
    logic        clear_req;
    logic        writeback_req;
    logic [31:0] wb_key;
    logic [63:0] wb_block;
  } rsp_t;

endpackage

@@ rtl/core/bbc_req_if.sv @@
// Request channel of the block buffer cache: valid, ready and one request item.
interface bbc_req_if;
  logic          valid;
  logic          ready;
  bbc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bbc_rsp_if.sv @@
// Result channel of the block buffer cache: valid, ready and one result item.
interface bbc_rsp_if;
  logic          valid;
  logic          ready;
  bbc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bbc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module bbc_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/block_buffer_cache_clock.sv @@
// Top level of the block buffer cache tag and policy engine with clock replacement.
//
// Usage: requests enter on req_i (get, new, mark dirty, release) and each one
// yields exactly one result item on rsp_o. Both channels move an item when
// valid and ready are high at a rising edge. One request is worked at a time;
// req_i.ready is high only while the sequencer is idle.
// Mark dirty, a get of block zero and a failed release go from idle straight
// to the result; a release passes through the pin drop step. A get or new
// scans the tag RAM, read one slot a cycle through a single shared 96-bit
// comparator; a hit pins the slot, while a miss sweeps the clock hand, which
// checks one slot a cycle and then takes an aged slot or reports all busy.
// Results sit in an output register: a new request is taken while an older
// result waits, and a finished result waits in the sequencer while the
// receiver stalls. Reset empties the cache at once (valid, pin, dirty and age
// flags are flip-flops), parks the hand at slot 0 and drops any pending result.
module block_buffer_cache_clock #(
  parameter int NumSlots = bbc_pkg::NumSlotsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bbc_req_if.sink   req_i,
  bbc_rsp_if.source rsp_o
);

  localparam int IdxW  = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int ScanW = $clog2(NumSlots + 1);

  // Sequencer and per-slot flags
  bbc_pkg::state_e      state_q, state_d;
  logic [NumSlots-1:0]  valid_q, valid_d;
  logic [NumSlots-1:0]  pinned_q, pinned_d;
  logic [NumSlots-1:0]  dirty_q, dirty_d;
  logic [NumSlots-1:0]  aged_q, aged_d;
  logic [IdxW-1:0]      hand_q, hand_d;
  logic [1:0]           wraps_q, wraps_d;
  logic [ScanW-1:0]     scan_q, scan_d;
  logic                 pend_q, pend_d;
  logic                 rsp_valid_q, rsp_valid_d;

  // Payload registers
  bbc_pkg::req_t        req_q, req_d;
  logic [IdxW-1:0]      slot_q, slot_d;
  logic [IdxW-1:0]      pidx_q, pidx_d;
  bbc_pkg::rsp_t        wr_q, wr_d;
  bbc_pkg::rsp_t        rsp_q, rsp_d;

  // RAM ports
  logic                   tag_we;
  logic [IdxW-1:0]        tag_waddr, tag_raddr;
  bbc_pkg::tag_t          tag_wdata, tag_rdata;
  logic                   pin_we;
  logic [IdxW-1:0]        pin_waddr, pin_raddr;
  logic [bbc_pkg::PinW-1:0] pin_wdata, pin_rdata;

  // Shared conditions
  logic            sel_in_range;
  logic [IdxW-1:0] sidx_in;
  logic            rel_ok;
  logic            get_zero;
  bbc_pkg::tag_t   tag_key;
  logic            scan_hit;
  logic            scan_miss;
  logic            hand_last;
  logic [IdxW-1:0] hand_nx;
  logic [1:0]      wraps_nx;
  logic            sw_busy;
  logic            sw_take;
  logic            out_free;

  bbc_ram #(
    .Width ($bits(bbc_pkg::tag_t)),
    .Depth (NumSlots)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  bbc_ram #(
    .Width (bbc_pkg::PinW),
    .Depth (NumSlots)
  ) u_pin_ram (
    .clk_i   (clk_i),
    .we_i    (pin_we),
    .waddr_i (pin_waddr),
    .wdata_i (pin_wdata),
    .raddr_i (pin_raddr),
    .rdata_o (pin_rdata)
  );

  // Decode the incoming request and the compare and sweep conditions
  always_comb begin
    sel_in_range = (32'(req_i.data.slot_sel) < NumSlots);
    sidx_in      = IdxW'(req_i.data.slot_sel);
    rel_ok       = sel_in_range && pinned_q[sidx_in] && !aged_q[sidx_in];
    get_zero     = (req_i.data.kind == bbc_pkg::KindGet) && (req_i.data.block_no == '0);
    tag_key      = '{owner: req_q.owner_key, block: req_q.block_no};
    scan_hit     = pend_q && valid_q[pidx_q] && (tag_rdata == tag_key);
    scan_miss    = pend_q && !scan_hit && (scan_q == ScanW'(NumSlots));
    hand_last    = (hand_q == IdxW'(NumSlots - 1));
    hand_nx      = hand_last ? '0 : hand_q + 1'b1;
    wraps_nx     = wraps_q + {1'b0, hand_last};
    sw_busy      = hand_last && (wraps_q == 2'd2);
    sw_take      = !sw_busy && aged_q[hand_nx];
    out_free     = !rsp_valid_q || rsp_o.ready;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbc_pkg::StIdle: begin
        if (req_i.valid) begin
          unique case (req_i.data.kind)
            bbc_pkg::KindGet, bbc_pkg::KindNew: begin
              state_d = get_zero ? bbc_pkg::StDone : bbc_pkg::StScan;
            end
            bbc_pkg::KindDirty: begin
              state_d = bbc_pkg::StDone;
            end
            bbc_pkg::KindRelease: begin
              state_d = rel_ok ? bbc_pkg::StRel : bbc_pkg::StDone;
            end
          endcase
        end
      end
      bbc_pkg::StScan: begin
        priority if (scan_hit) begin
          state_d = bbc_pkg::StPinWr;
        end else if (scan_miss) begin
          state_d = bbc_pkg::StSweep;
        end
      end
      bbc_pkg::StSweep: begin
        priority if (sw_busy) begin
          state_d = bbc_pkg::StDone;
        end else if (sw_take) begin
          state_d = bbc_pkg::StTake;
        end
      end
      bbc_pkg::StPinWr, bbc_pkg::StTake, bbc_pkg::StRel: begin
        state_d = bbc_pkg::StDone;
      end
      bbc_pkg::StDone: begin
        if (out_free) begin
          state_d = bbc_pkg::StIdle;
        end
      end
      default: state_d = bbc_pkg::StIdle;
    endcase
  end

  // Datapath and flag updates per state
  always_comb begin
    req_d       = req_q;
    slot_d      = slot_q;
    pidx_d      = pidx_q;
    wr_d        = wr_q;
    valid_d     = valid_q;
    pinned_d    = pinned_q;
    dirty_d     = dirty_q;
    aged_d      = aged_q;
    hand_d      = hand_q;
    wraps_d     = wraps_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    tag_we      = 1'b0;
    tag_waddr   = slot_q;
    tag_wdata   = tag_key;
    tag_raddr   = slot_q;
    pin_we      = 1'b0;
    pin_waddr   = slot_q;
    pin_wdata   = '0;
    pin_raddr   = slot_q;

    unique case (state_q)
      bbc_pkg::StIdle: begin
        // Latch the request; settle mark dirty, a get of block zero and a failed release
        if (req_i.valid) begin
          req_d   = req_i.data;
          wr_d    = '0;
          scan_d  = '0;
          wraps_d = '0;
          slot_d  = sidx_in;
          unique case (req_i.data.kind)
            bbc_pkg::KindGet, bbc_pkg::KindNew: begin
              if (get_zero) begin
                wr_d.status = bbc_pkg::StatNoBlock;
              end
            end
            bbc_pkg::KindDirty: begin
              wr_d.slot = req_i.data.slot_sel;
              if (sel_in_range) begin
                dirty_d[sidx_in] = 1'b1;
              end
            end
            bbc_pkg::KindRelease: begin
              wr_d.slot = req_i.data.slot_sel;
              tag_raddr = sidx_in;
              pin_raddr = sidx_in;
              if (!rel_ok) begin
                wr_d.status = bbc_pkg::StatNotPinned;
              end
            end
          endcase
        end
      end
      bbc_pkg::StScan: begin
        // Compare the slot read last cycle, read the next one
        if (scan_hit) begin
          slot_d    = pidx_q;
          pin_raddr = pidx_q;
        end else if (scan_q < ScanW'(NumSlots)) begin
          tag_raddr = scan_q[IdxW-1:0];
          pidx_d    = scan_q[IdxW-1:0];
          pend_d    = 1'b1;
          scan_d    = scan_q + 1'b1;
        end
      end
      bbc_pkg::StPinWr: begin
        // Pin the hit slot; an idle or aged slot restarts at one
        pin_we = 1'b1;
        if (pinned_q[slot_q]) begin
          pin_wdata = (pin_rdata == bbc_pkg::PinMax) ? pin_rdata : pin_rdata + 1'b1;
        end else begin
          pin_wdata = bbc_pkg::PinW'(1);
        end
        pinned_d[slot_q] = 1'b1;
        aged_d[slot_q]   = 1'b0;
        wr_d.hit         = 1'b1;
        wr_d.slot        = 4'(slot_q);
        if (req_q.kind == bbc_pkg::KindNew) begin
          wr_d.clear_req  = 1'b1;
          dirty_d[slot_q] = 1'b1;
        end
      end
      bbc_pkg::StSweep: begin
        // Advance the hand one slot to take an aged slot or age an idle one, or give up and park it at slot 0
        priority if (sw_busy) begin
          hand_d      = '0;
          wr_d.status = bbc_pkg::StatBusy;
        end else if (sw_take) begin
          hand_d          = hand_nx;
          slot_d          = hand_nx;
          tag_raddr       = hand_nx;
          aged_d[hand_nx] = 1'b0;
          if (dirty_q[hand_nx]) begin
            wr_d.writeback_req = 1'b1;
            dirty_d[hand_nx]   = 1'b0;
          end
        end else begin
          hand_d  = hand_nx;
          wraps_d = wraps_nx;
          if (!pinned_q[hand_nx]) begin
            aged_d[hand_nx] = 1'b1;
          end
        end
      end
      bbc_pkg::StTake: begin
        // Retag the taken slot with one pin; hand out the old tag if dirty
        if (wr_q.writeback_req) begin
          wr_d.wb_key   = tag_rdata.owner;
          wr_d.wb_block = tag_rdata.block;
        end
        tag_we           = 1'b1;
        pin_we           = 1'b1;
        pin_wdata        = bbc_pkg::PinW'(1);
        valid_d[slot_q]  = 1'b1;
        pinned_d[slot_q] = 1'b1;
        wr_d.slot        = 4'(slot_q);
        if (req_q.kind == bbc_pkg::KindNew) begin
          wr_d.clear_req  = 1'b1;
          dirty_d[slot_q] = 1'b1;
        end else begin
          wr_d.fetch_req  = 1'b1;
          dirty_d[slot_q] = 1'b0;
        end
      end
      bbc_pkg::StRel: begin
        // Drop one pin and write back a dirty slot
        pin_we    = 1'b1;
        pin_wdata = pin_rdata - 1'b1;
        if (pin_rdata == bbc_pkg::PinW'(1)) begin
          pinned_d[slot_q] = 1'b0;
        end
        if (dirty_q[slot_q]) begin
          wr_d.writeback_req = 1'b1;
          wr_d.wb_key        = tag_rdata.owner;
          wr_d.wb_block      = tag_rdata.block;
          dirty_d[slot_q]    = 1'b0;
        end
      end
      bbc_pkg::StDone: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          rsp_d       = wr_q;
          rsp_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbc_pkg::StIdle;
      valid_q     <= '0;
      pinned_q    <= '0;
      dirty_q     <= '0;
      aged_q      <= '0;
      hand_q      <= '0;
      wraps_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pinned_q    <= pinned_d;
      dirty_q     <= dirty_d;
      aged_q      <= aged_d;
      hand_q      <= hand_d;
      wraps_q     <= wraps_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    slot_q <= slot_d;
    pidx_q <= pidx_d;
    wr_q   <= wr_d;
    rsp_q  <= rsp_d;
  end

  assign req_i.ready = (state_q == bbc_pkg::StIdle);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // A slot is never both pinned and aged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pinned_q & aged_q) == '0))
    else $error("slot pinned and aged at once");

  // The hand never completes more than two wraps in a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbc_pkg::StSweep) |-> (wraps_q != 2'd3))
    else $error("sweep wrap count overran");

  // An accepted request always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != bbc_pkg::StIdle))
    else $error("request accepted without starting work");

  // An all-busy result points at slot zero with no hit and no fetch or write-back request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.data.status == bbc_pkg::StatBusy)) |->
      ((rsp_o.data.slot == '0) && !rsp_o.data.hit && !rsp_o.data.fetch_req &&
       !rsp_o.data.writeback_req))
    else $error("all-busy result carries slot data");

  // A hit never asks for a fetch or a write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.hit) |->
      (!rsp_o.data.fetch_req && !rsp_o.data.writeback_req))
    else $error("hit result requests block traffic");

endmodule
